### design/twhrt_pkg.sv
// shared constants, codes and command/status types of the hashed ref table
// no dependencies; compiled first
package twhrt_pkg;

  localparam int MaxBucketsLog2Def = 10;
  localparam int Ways              = 2;
  localparam int KeyW              = 64;
  localparam int CountW            = 32;
  localparam int SlotW             = KeyW + CountW;
  localparam int RowW              = Ways * SlotW;
  localparam int CfgW              = 32;

  localparam logic [35:0] HashPrime = 36'd32212254719;
  // floor(2**66 / prime), scales the top 30 bits of the hash into a quotient estimate
  localparam logic [31:0] HashRecip = 32'h8888_8888;

  localparam logic [1:0] ACT_GET     = 2'd0;
  localparam logic [1:0] ACT_TAKE    = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;

  localparam logic [2:0] ST_HIT         = 3'd0;
  localparam logic [2:0] ST_INSERTED    = 3'd1;
  localparam logic [2:0] ST_DECREMENTED = 3'd2;
  localparam logic [2:0] ST_REMOVED     = 3'd3;
  localparam logic [2:0] ST_FULL        = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND   = 3'd5;
  localparam logic [2:0] ST_BAD_KEY     = 3'd6;

  localparam logic [1:0] CFG_MULT = 2'd0;
  localparam logic [1:0] CFG_ADD  = 2'd1;
  localparam logic [1:0] CFG_LOG2 = 2'd2;

  typedef struct packed {
    logic in_ready;
    logic mul_lo;
    logic mul_hi;
    logic sum;
    logic recip;
    logic fold;
    logic corr;
    logic rd_en;
    logic eval;
    logic clr_write;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic out_busy;
    logic clr_last;
  } stat_t;

endpackage

### design/twhrt_if.sv
// request and response channel interfaces of the hashed ref table
// depends on twhrt_pkg; compiled after the package
interface twhrt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [63:0] key;
  modport source (output valid, action, key, input ready);
  modport sink   (input valid, action, key, output ready);
endinterface

interface twhrt_out_if import twhrt_pkg::*; #(parameter int BucketW = MaxBucketsLog2Def);
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [BucketW-1:0] bucket_index;
  logic               slot_index;
  logic [31:0]        ref_count;
  modport source (output valid, status, bucket_index, slot_index, ref_count, input ready);
  modport sink   (input valid, status, bucket_index, slot_index, ref_count, output ready);
endinterface

### design/twhrt_ctrl.sv
// sequencer of the hashed ref table: clear sweep, hash, modulo, bucket rmw
// depends on twhrt_pkg
module twhrt_ctrl import twhrt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_MUL_LO = 4'd2;
  localparam logic [3:0] S_MUL_HI = 4'd3;
  localparam logic [3:0] S_SUM    = 4'd4;
  localparam logic [3:0] S_RECIP  = 4'd5;
  localparam logic [3:0] S_FOLD   = 4'd6;
  localparam logic [3:0] S_CORR   = 4'd7;
  localparam logic [3:0] S_READ   = 4'd8;
  localparam logic [3:0] S_EVAL   = 4'd9;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_write = 1'b1;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (stat_i.in_valid) state_d = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_RECIP;
      end
      S_RECIP: begin
        cmd_o.recip = 1'b1;
        state_d     = S_FOLD;
      end
      S_FOLD: begin
        cmd_o.fold = 1'b1;
        state_d    = S_CORR;
      end
      S_CORR: begin
        cmd_o.corr = 1'b1;
        state_d    = S_READ;
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_EVAL;
      end
      S_EVAL: begin
        if (!stat_i.out_busy) begin
          cmd_o.eval = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_CLEAR;
    else         state_q <= state_d;
  end

`ifndef SYNTHESIS
  a_eval_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.eval |-> !stat_i.out_busy) else $error("result committed over a waiting beat");
  a_corr_to_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CORR) |=> state_q == S_READ)
    else $error("modulo did not hand over to bucket read");
  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.in_ready && stat_i.in_valid) |=> state_q == S_MUL_LO)
    else $error("accepted beat did not start hashing");
`endif

endmodule

### design/twhrt_dp.sv
// datapath of the hashed ref table: config regs, hash, modulo, bucket store, result reg
// depends on twhrt_pkg and twhrt_if
module twhrt_dp import twhrt_pkg::*; #(
  parameter int MAX_BUCKETS_LOG2 = MaxBucketsLog2Def
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i,
  twhrt_in_if.sink        in_i,
  twhrt_out_if.source     out_o,
  input  cmd_t            cmd_i,
  output stat_t           stat_o
);

  localparam int BW   = MAX_BUCKETS_LOG2;
  localparam int Rows = 1 << BW;
  localparam logic [36:0] PrimeX1 = {1'b0, HashPrime};
  localparam logic [36:0] PrimeX2 = {HashPrime, 1'b0};

  logic [31:0] mult_q, add_q;
  logic [3:0]  log2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mult_q <= 32'd1;
      add_q  <= 32'd0;
      log2_q <= 4'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MULT: mult_q <= cfg_data_i;
        CFG_ADD:  add_q  <= cfg_data_i;
        CFG_LOG2: log2_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // request capture and hash
  logic [1:0]  action_q;
  logic [63:0] key_q, prod_q, x_q;
  logic [31:0] hi_q, mul_a, mul_b;
  logic [63:0] mul_res;
  logic [29:0] quo_q;
  logic [36:0] quo_ext, fold_d, fold_q;
  logic [34:0] rem_q, rem_d;
  logic        load_in;

  assign load_in = cmd_i.in_ready && in_i.valid;
  // shared multiplier: the two hash product halves, then the quotient estimate
  assign mul_a   = cmd_i.recip ? HashRecip : mult_q;
  assign mul_b   = cmd_i.mul_hi ? key_q[63:32] :
                   cmd_i.recip  ? {2'b00, x_q[63:34]} : key_q[31:0];
  assign mul_res = mul_a * mul_b;

  // prime is 2**35 - 2**31 - 1; the estimate is at most two short of the
  // quotient, so the partial remainder is below 2**37 and 37-bit math is exact
  assign quo_ext = {7'd0, quo_q};
  assign fold_d  = x_q[36:0] + quo_ext + {quo_ext[5:0], 31'd0} - {quo_ext[1:0], 35'd0};

  // final correction, at most two primes over
  always_comb begin
    logic [36:0] r;
    r = fold_q;
    if (r >= PrimeX2)      r = r - PrimeX2;
    else if (r >= PrimeX1) r = r - PrimeX1;
    rem_d = r[34:0];
  end

  always_ff @(posedge clk_i) begin
    if (load_in) begin
      action_q <= in_i.action;
      key_q    <= in_i.key;
    end
    if (cmd_i.mul_lo) prod_q <= mul_res;
    if (cmd_i.mul_hi) hi_q   <= mul_res[31:0];
    if (cmd_i.sum)    x_q    <= prod_q + {hi_q, 32'd0} + {32'd0, add_q};
    if (cmd_i.recip)  quo_q  <= mul_res[61:32];
    if (cmd_i.fold)   fold_q <= fold_d;
    if (cmd_i.corr)   rem_q  <= rem_d;
  end

  // bucket select with clamped bucket count
  logic [BW-1:0] mask, bucket, bucket_q;
  always_comb begin
    int eff;
    eff = int'(log2_q);
    if (eff < 1) eff = 1;
    if (eff > BW) eff = BW;
    for (int i = 0; i < BW; i++) mask[i] = (i < eff);
    bucket = rem_q[BW-1:0] & mask;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) bucket_q <= bucket;
  end

  // bucket store, one row per bucket
  logic [RowW-1:0] mem [Rows];
  logic [RowW-1:0] row_q, new_row;
  logic [BW-1:0]   clr_cnt_q;
  logic            upd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)              clr_cnt_q <= '0;
    else if (cmd_i.clr_write) clr_cnt_q <= clr_cnt_q + BW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_write)          mem[clr_cnt_q] <= '0;
    else if (cmd_i.eval && upd)   mem[bucket_q]  <= new_row;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) row_q <= mem[bucket];
  end

  // bucket update
  logic [2:0]        res_status;
  logic              res_slot;
  logic [CountW-1:0] res_cnt;

  always_comb begin
    logic [KeyW-1:0]   k0, k1;
    logic [CountW-1:0] c0, c1, fcnt;
    logic              keynz, hit0, hit1, found, fslot;
    k0    = row_q[KeyW-1:0];
    c0    = row_q[SlotW-1:KeyW];
    k1    = row_q[SlotW+KeyW-1:SlotW];
    c1    = row_q[RowW-1:SlotW+KeyW];
    keynz = key_q != '0;
    hit0  = keynz && (k0 == key_q);
    hit1  = keynz && (k1 == key_q);
    found = hit0 || hit1;
    fslot = !hit0;
    fcnt  = hit0 ? c0 : c1;
    res_status = ST_BAD_KEY;
    res_slot   = 1'b0;
    res_cnt    = '0;
    upd        = 1'b0;
    new_row    = row_q;
    if (!keynz) begin
      res_status = ST_BAD_KEY;
    end else if (action_q == ACT_RELEASE) begin
      if (!found) begin
        res_status = ST_NOT_FOUND;
      end else if (fcnt > 32'd1) begin
        res_status = ST_DECREMENTED;
        res_slot   = fslot;
        res_cnt    = fcnt - 32'd1;
        upd        = 1'b1;
        new_row[SlotW*int'(fslot) +: SlotW] = {res_cnt, key_q};
      end else begin
        res_status = ST_REMOVED;
        res_slot   = fslot;
        upd        = 1'b1;
        new_row[SlotW*int'(fslot) +: SlotW] = '0;
      end
    end else if (found) begin
      res_status = ST_HIT;
      res_slot   = fslot;
      res_cnt    = (action_q == ACT_TAKE && fcnt != '1) ? fcnt + 32'd1 : fcnt;
      upd        = 1'b1;
      new_row[SlotW*int'(fslot) +: SlotW] = {res_cnt, key_q};
    end else if (k0 == '0 || k1 == '0) begin
      res_status = ST_INSERTED;
      res_slot   = (k0 != '0);
      res_cnt    = (action_q == ACT_TAKE) ? 32'd1 : 32'd0;
      upd        = 1'b1;
      new_row[SlotW*int'(res_slot) +: SlotW] = {res_cnt, key_q};
    end else begin
      res_status = ST_FULL;
    end
  end

  // result register
  logic out_valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)          out_valid_q <= 1'b0;
    else if (cmd_i.eval)  out_valid_q <= 1'b1;
    else if (out_o.ready) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      out_o.status       <= res_status;
      out_o.bucket_index <= bucket_q;
      out_o.slot_index   <= res_slot;
      out_o.ref_count    <= res_cnt;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign in_i.ready      = cmd_i.in_ready;
  assign stat_o.in_valid = in_i.valid;
  assign stat_o.out_busy = out_valid_q && !out_o.ready;
  assign stat_o.clr_last = clr_cnt_q == BW'(Rows - 1);

endmodule

### design/two_way_hashed_ref_table_unit.sv
// top level of the two-way hashed reference count table
// depends on twhrt_pkg, twhrt_if, twhrt_ctrl and twhrt_dp

// Keyed table of 32-bit reference counts in 2-slot buckets, one request beat in,
// one response beat out. After reset a clearing pass writes every bucket row to
// empty, during which no request is taken; config writes are taken at any time.
// Each request then runs from one accept to the next through an idle state, the
// low and high halves of the 64-bit hash product on the shared 32x32 multiplier,
// an add, the mod-prime remainder (a quotient estimate on the same multiplier, a
// fold by shifts and adds, a correction that takes off at most twice the prime),
// a bucket row read and a read-modify-write that also loads the response
// register. The response register lets the next request start while a
// response beat still waits; the update cycle holds only if the previous
// response has not been taken.
module two_way_hashed_ref_table_unit import twhrt_pkg::*; #(
  parameter int MAX_BUCKETS_LOG2 = MaxBucketsLog2Def
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // config write port, registers as listed: mult, add, bucket count log2
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i,
  // request and response channels
  twhrt_in_if.sink        in_i,
  twhrt_out_if.source     out_o
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  twhrt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // hash, remainder, bucket store and response register
  twhrt_dp #(
    .MAX_BUCKETS_LOG2 (MAX_BUCKETS_LOG2)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .out_o      (out_o),
    .cmd_i      (cmd),
    .stat_o     (stat)
  );

endmodule

### verif/tb_two_way_hashed_ref_table_unit.sv
// testbench for the two-way hashed reference count table
// depends on twhrt_pkg, twhrt_if and the table top level; a class scoreboard predicts every response beat
module tb_two_way_hashed_ref_table_unit;
  import twhrt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  bucket;
    logic        slot;
    logic [31:0] count;
  } resp_t;

  // shadow of the table and its hash settings, with the queue of pending responses
  class refcount_scoreboard;
    logic [63:0] keys [2048];
    logic [31:0] refs [2048];
    logic [31:0] mult;
    logic [31:0] addend;
    logic [3:0]  lg;
    resp_t       pending[$];
    int          errors;

    function void clear();
      foreach (keys[i]) begin
        keys[i] = '0;
        refs[i] = '0;
      end
      mult = 32'd1;
      addend = '0;
      lg = 4'd1;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      if (idx == CFG_MULT) mult = val;
      else if (idx == CFG_ADD) addend = val;
      else if (idx == CFG_LOG2) lg = val[3:0];
    endfunction

    function logic [9:0] bucket_of(logic [63:0] key);
      logic [63:0] h;
      int n;
      h = 64'(mult) * key + 64'(addend);
      h = h % 64'(HashPrime);
      n = (lg < 1) ? 1 : (lg > 10) ? 10 : lg;
      return 10'(h & ((64'd1 << n) - 1));
    endfunction

    // work out the response of one accepted request and update the shadow
    function void note_request(logic [1:0] act, logic [63:0] key);
      resp_t r;
      int b;
      bit hit;
      bit placed;
      r = '0;
      r.bucket = bucket_of(key);
      b = r.bucket * 2;
      hit = 0;
      for (int j = 0; j < 2; j++)
        if (!hit && key != 0 && keys[b+j] == key) begin
          hit = 1;
          r.slot = j[0];
        end
      if (key == 0) begin
        r.status = ST_BAD_KEY;
      end else if (act == ACT_RELEASE) begin
        if (!hit) begin
          r.status = ST_NOT_FOUND;
        end else if (refs[b+r.slot] > 1) begin
          refs[b+r.slot]--;
          r.count = refs[b+r.slot];
          r.status = ST_DECREMENTED;
        end else begin
          keys[b+r.slot] = '0;
          refs[b+r.slot] = '0;
          r.status = ST_REMOVED;
        end
      end else if (hit) begin
        if (act == ACT_TAKE && refs[b+r.slot] != 32'hFFFF_FFFF) refs[b+r.slot]++;
        r.count = refs[b+r.slot];
        r.status = ST_HIT;
      end else begin
        placed = 0;
        for (int j = 0; j < 2; j++)
          if (!placed && keys[b+j] == 0) begin
            placed = 1;
            r.slot = j[0];
          end
        if (placed) begin
          r.count = (act == ACT_TAKE) ? 32'd1 : 32'd0;
          keys[b+r.slot] = key;
          refs[b+r.slot] = r.count;
          r.status = ST_INSERTED;
        end else begin
          r.status = ST_FULL;
        end
      end
      pending.push_back(r);
    endfunction

    function void check_response(resp_t got);
      resp_t e;
      if (pending.size() == 0) begin
        $error("response beat with nothing pending");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, got.status);
        errors++;
      end
      if (got.bucket !== e.bucket) begin
        $error("bucket_index exp %0d got %0d", e.bucket, got.bucket);
        errors++;
      end
      if (got.slot !== e.slot) begin
        $error("slot_index exp %0d got %0d", e.slot, got.slot);
        errors++;
      end
      if (got.count !== e.count) begin
        $error("ref_count exp %0d got %0d", e.count, got.count);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;

  twhrt_in_if  req_if();
  twhrt_out_if rsp_if();

  two_way_hashed_ref_table_unit i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_i(req_if.sink), .out_o(rsp_if.source)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  refcount_scoreboard sb = new();
  int  beats_sent;
  int  beats_seen;
  int  hold_cycles;      // receiver hold-off requested by the stimulus
  bit  stimulus_done;
  logic [63:0] key_pool[16];

  initial begin
    req_if.valid = 1'b0;
    req_if.action = '0;
    req_if.key = '0;
    rsp_if.ready = 1'b0;
  end

  // receiver: own stall pattern plus a long hold-off on request
  always @(posedge clk_i) begin
    if (rsp_if.valid && rsp_if.ready && rst_ni) begin
      sb.check_response({rsp_if.status, rsp_if.bucket_index, rsp_if.slot_index,
                         rsp_if.ref_count});
      beats_seen++;
    end
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      rsp_if.ready <= 1'b0;
    end else if (beats_seen % 64 < 20) begin
      // stretch with no stalls
      rsp_if.ready <= 1'b1;
    end else begin
      rsp_if.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // one request beat; valid stays high across back-to-back beats
  task automatic send_req(logic [1:0] act, logic [63:0] key, bit keep);
    req_if.valid <= 1'b1;
    req_if.action <= act;
    req_if.key <= key;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(act, key);
    beats_sent++;
    if (!keep) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    // a request whose response is still in flight leaves nothing pending unseen;
    // give the pipeline its full latency before touching the registers
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  // random request: mostly keys from a small pool, so hits, full buckets and removals occur
  task automatic random_burst(int n);
    logic [1:0]  act;
    logic [63:0] key;
    for (int i = 0; i < n; i++) begin
      act = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
        0:       key = {$urandom, $urandom};
        1:       key = '0;
        default: key = key_pool[$urandom_range(0, 15)];
      endcase
      send_req(act, key, i != n - 1);
    end
  endtask

  task automatic random_phase(int n);
    int done_cnt;
    done_cnt = 0;
    while (done_cnt < n) begin
      random_burst($urandom_range(1, 8));
      done_cnt = beats_sent;
      repeat ($urandom_range(0, 5)) @(posedge clk_i);
      done_cnt = done_cnt - 0;
      if (beats_sent >= n) break;
    end
  endtask

  task automatic new_pool(bit wide);
    foreach (key_pool[i])
      key_pool[i] = wide ? {$urandom, $urandom} : 64'($urandom_range(1, 40));
  endtask

  initial begin
    int base;
    sb.clear();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: identity hash over two buckets
    send_req(ACT_GET, 64'd0, 0);                    // bad key
    send_req(ACT_RELEASE, 64'd2, 0);                // not found
    send_req(ACT_GET, 64'd2, 0);                    // insert count 0
    send_req(ACT_TAKE, 64'd4, 0);                   // insert count 1, second slot
    send_req(ACT_TAKE, 64'd6, 0);                   // bucket full
    send_req(ACT_TAKE, 64'd2, 1);                   // hit, increment
    send_req(2'd3, 64'd2, 1);                       // unused action acts as plain get
    send_req(ACT_TAKE, 64'd2, 0);
    send_req(ACT_RELEASE, 64'd2, 0);                // decrement
    send_req(ACT_RELEASE, 64'd2, 0);                // removed at one
    send_req(ACT_RELEASE, 64'd4, 0);                // removed
    send_req(ACT_GET, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    send_req(ACT_RELEASE, 64'hFFFF_FFFF_FFFF_FFFF, 0); // removed at zero
    send_req(ACT_TAKE, 64'hAAAA_5555_AAAA_5555, 0);
    send_req(ACT_TAKE, 64'h5555_AAAA_5555_AAAA, 0);
    drain();

    // extreme hash settings, out-of-range bucket counts
    write_reg(CFG_MULT, 32'hFFFF_FFFF);
    write_reg(CFG_ADD, 32'hFFFF_FFFF);
    write_reg(CFG_LOG2, 32'd15);
    send_req(ACT_TAKE, 64'h8000_0000_0000_0001, 0);
    send_req(ACT_GET, 64'd0, 0);
    drain();
    write_reg(CFG_LOG2, 32'd0);
    write_reg(CFG_MULT, 32'd0);                     // all keys share a bucket
    send_req(ACT_TAKE, 64'd77, 0);
    send_req(ACT_TAKE, 64'd78, 0);
    drain();

    // random phases over several settings
    base = 0;
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_MULT, (ph == 1) ? 32'd1 : $urandom);
      write_reg(CFG_ADD, (ph == 2) ? 32'd0 : $urandom);
      write_reg(CFG_LOG2, (ph == 3) ? 32'd10 : (ph == 4) ? 32'd1 :
                32'($urandom_range(0, 15)));
      new_pool(ph[0]);
      base = beats_sent;
      if (ph == 2) begin
        // long receiver hold-off while the sender keeps offering
        hold_cycles = 300;
        random_burst(20);
      end
      random_phase(base + 120);
      drain();                                      // sender pauses until all are back
    end
    stimulus_done = 1;
  end

  // finish
  initial begin
    wait (stimulus_done);
    repeat (50) @(posedge clk_i);
    $display("requests sent %0d, responses checked %0d over 9 hash settings",
             beats_sent, beats_seen);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #8ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule

### files.f
design/twhrt_pkg.sv
design/twhrt_if.sv
design/twhrt_ctrl.sv
design/twhrt_dp.sv
design/two_way_hashed_ref_table_unit.sv
verif/tb_two_way_hashed_ref_table_unit.sv
